>>> rtl/core/rasg_pkg.sv
`timescale 1ns / 1ps
// rasg_pkg: shared types and constants of the rotation arc / spoke generator
// no dependencies

package rasg_pkg;

   localparam int PIX_W      = 16;
   localparam int EXTENT_W   = 8;
   localparam int TURN_W     = 10;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 16;

   // rotation by about 2.5 degrees in q10
   localparam int ROT_COS   = 1023;
   localparam int ROT_SIN   = 45;
   localparam int ROT_SHIFT = 10;

   localparam logic [CSR_IDX_W-1:0] CSR_FIGURE_MODE      = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_CENTER_X         = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_CENTER_Y         = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_EXTENT           = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_TURN_STEPS       = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_FIRST_DRAWN_STEP = 3'd5;
   localparam logic [CSR_IDX_W-1:0] CSR_START_UP         = 3'd6;

   typedef struct packed {
      logic                    figure_mode;
      logic signed [PIX_W-1:0] center_x;
      logic signed [PIX_W-1:0] center_y;
      logic [EXTENT_W-1:0]     extent;
      logic [TURN_W-1:0]       turn_steps;
      logic [TURN_W-1:0]       first_drawn_step;
      logic                    start_up;
   } cfg_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DECIDE,
      ST_ROT_X,
      ST_ROT_Y,
      ST_EMIT
   } seq_state_type;

endpackage

>>> rtl/core/rasg_if.sv
`timescale 1ns / 1ps
// rasg_req_if / rasg_rsp_if: valid/ready channels of the generator
// depends on rasg_pkg

interface rasg_req_if import rasg_pkg::*; ();
   logic valid;
   logic ready;
   logic restart;

   modport source (output valid, output restart, input ready);
   modport sink (input valid, input restart, output ready);
endinterface

interface rasg_rsp_if import rasg_pkg::*; ();
   logic                    valid;
   logic                    ready;
   logic signed [PIX_W-1:0] pixel_x;
   logic signed [PIX_W-1:0] pixel_y;
   logic                    drawn;
   logic                    last;

   modport source (output valid, output pixel_x, output pixel_y, output drawn,
                   output last, input ready);
   modport sink (input valid, input pixel_x, input pixel_y, input drawn,
                 input last, output ready);
endinterface

>>> rtl/core/rasg_rot_unit.sv
`timescale 1ns / 1ps
// rasg_rot_unit: one half of a q10 rotation, asr(cos*a +/- sin*b, 10)
// depends on rasg_pkg

module rasg_rot_unit import rasg_pkg::*; #(
   parameter int VEC_BITS = 20
) (
   input  logic signed [VEC_BITS-1:0] a,
   input  logic signed [VEC_BITS-1:0] b,
   input  logic                       neg_b,
   output logic signed [VEC_BITS-1:0] result
);

   localparam int W = VEC_BITS + 12;

   logic signed [W-1:0] a_w;
   logic signed [W-1:0] b_w;
   logic signed [W-1:0] term_a;
   logic signed [W-1:0] term_b;
   logic signed [W-1:0] sum;
   logic signed [W-1:0] shifted;

   assign a_w     = W'(a);
   assign b_w     = W'(b);
   assign term_a  = a_w * W'(ROT_COS);
   assign term_b  = b_w * W'(ROT_SIN);
   assign sum     = neg_b ? (term_a - term_b) : (term_a + term_b);
   assign shifted = sum >>> ROT_SHIFT;
   assign result  = shifted[VEC_BITS-1:0];

endmodule

>>> rtl/core/rasg_seq.sv
`timescale 1ns / 1ps
// rasg_seq: sequencer and vector state; drives the shared rotation unit
// depends on rasg_pkg, rasg_if, rasg_rot_unit

module rasg_seq import rasg_pkg::*; #(
   parameter int FRAC_BITS = 10,
   parameter int STEP_BITS = 10
) (
   input  logic        clock,
   input  logic        reset,
   input  cfg_type     cfg,
   rasg_req_if.sink    req_chan,
   rasg_rsp_if.source  rsp_chan
);

   localparam int VEC_BITS = FRAC_BITS + 10;
   localparam int CW = ((STEP_BITS > TURN_W) ? STEP_BITS : TURN_W) + 1;

   seq_state_type state_ff, state_in;

   logic signed [VEC_BITS-1:0] vec_x_ff, vec_x_in;
   logic signed [VEC_BITS-1:0] vec_y_ff, vec_y_in;
   logic signed [VEC_BITS-1:0] tmp_x_ff, tmp_x_in;
   logic [STEP_BITS-1:0]       step_ff, step_in;
   logic [TURN_W-1:0]          iter_ff, iter_in;
   logic                       finished_ff, finished_in;
   logic                       idle_ff, idle_in;

   logic                       rsp_valid_ff, rsp_valid_in;
   logic signed [PIX_W-1:0]    px_ff, px_in;
   logic signed [PIX_W-1:0]    py_ff, py_in;
   logic                       drawn_ff, drawn_in;
   logic                       last_ff, last_in;

   logic                       accept;
   logic                       out_free;
   logic [CW-1:0]              step_w;
   logic [CW-1:0]              count_w;
   logic                       empty;
   logic                       last_pt;
   logic                       rot_done;
   logic signed [VEC_BITS-1:0] ext_vec;
   logic signed [VEC_BITS-1:0] load_ext;
   logic signed [VEC_BITS-1:0] load_step;
   logic signed [VEC_BITS-1:0] ix;
   logic signed [VEC_BITS-1:0] iy;
   logic signed [VEC_BITS-1:0] rot_a;
   logic signed [VEC_BITS-1:0] rot_b;
   logic                       rot_neg;
   logic signed [VEC_BITS-1:0] rot_res;

   assign req_chan.ready   = (state_ff == ST_IDLE);
   assign accept           = req_chan.valid && (state_ff == ST_IDLE);
   assign out_free         = !rsp_valid_ff || rsp_chan.ready;

   assign rsp_chan.valid   = rsp_valid_ff;
   assign rsp_chan.pixel_x = px_ff;
   assign rsp_chan.pixel_y = py_ff;
   assign rsp_chan.drawn   = drawn_ff;
   assign rsp_chan.last    = last_ff;

   assign step_w  = CW'(step_ff);
   assign count_w = cfg.figure_mode ? CW'(cfg.extent) : CW'(cfg.turn_steps);
   assign empty   = finished_ff || (step_w >= count_w);
   assign last_pt = ((step_w + CW'(1)) >= count_w) || (&step_ff);
   assign rot_done = !cfg.figure_mode ||
                     (({1'b0, iter_ff} + (TURN_W + 1)'(1)) == {1'b0, cfg.turn_steps});

   assign ext_vec   = VEC_BITS'(cfg.extent) <<< FRAC_BITS;
   assign load_ext  = cfg.start_up ? -ext_vec : ext_vec;
   assign load_step = VEC_BITS'({step_ff, {FRAC_BITS{1'b0}}});
   assign ix        = vec_x_ff >>> FRAC_BITS;
   assign iy        = vec_y_ff >>> FRAC_BITS;

   // second half of a rotation uses the old x, still in vec_x; the new x waits in tmp
   assign rot_a   = (state_ff == ST_ROT_Y) ? vec_y_ff : vec_x_ff;
   assign rot_b   = (state_ff == ST_ROT_Y) ? vec_x_ff : vec_y_ff;
   assign rot_neg = (state_ff == ST_ROT_Y);

   rasg_rot_unit #(
      .VEC_BITS (VEC_BITS)
   ) u_rot (
      .a      (rot_a),
      .b      (rot_b),
      .neg_b  (rot_neg),
      .result (rot_res)
   );

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) state_in = ST_DECIDE;
         end
         ST_DECIDE: begin
            if (!empty && cfg.figure_mode && (cfg.turn_steps != '0)) state_in = ST_ROT_X;
            else state_in = ST_EMIT;
         end
         ST_ROT_X: state_in = ST_ROT_Y;
         ST_ROT_Y: begin
            if (!rot_done) state_in = ST_ROT_X;
            else if (cfg.figure_mode) state_in = ST_EMIT;
            else state_in = ST_IDLE;
         end
         ST_EMIT: begin
            if (out_free) begin
               if (!idle_ff && !cfg.figure_mode) state_in = ST_ROT_X;
               else state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      vec_x_in     = vec_x_ff;
      vec_y_in     = vec_y_ff;
      tmp_x_in     = tmp_x_ff;
      step_in      = step_ff;
      iter_in      = iter_ff;
      finished_in  = finished_ff;
      idle_in      = idle_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_chan.ready;
      px_in        = px_ff;
      py_in        = py_ff;
      drawn_in     = drawn_ff;
      last_in      = last_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept && req_chan.restart) begin
               vec_x_in    = '0;
               vec_y_in    = load_ext;
               step_in     = '0;
               finished_in = 1'b0;
            end
         end
         ST_DECIDE: begin
            idle_in = empty;
            iter_in = '0;
            if (!empty && cfg.figure_mode) begin
               vec_x_in = '0;
               vec_y_in = load_step;
            end
         end
         ST_ROT_X: begin
            tmp_x_in = rot_res;
         end
         ST_ROT_Y: begin
            vec_x_in = tmp_x_ff;
            vec_y_in = rot_res;
            iter_in  = iter_ff + TURN_W'(1);
         end
         ST_EMIT: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               if (idle_ff) begin
                  px_in       = '0;
                  py_in       = '0;
                  drawn_in    = 1'b0;
                  last_in     = 1'b1;
                  finished_in = 1'b1;
               end else begin
                  px_in    = cfg.center_x + PIX_W'(ix);
                  py_in    = cfg.center_y + PIX_W'(iy);
                  drawn_in = cfg.figure_mode || (step_w >= CW'(cfg.first_drawn_step));
                  last_in  = last_pt;
                  iter_in  = '0;
                  if (last_pt) finished_in = 1'b1;
                  else step_in = step_ff + STEP_BITS'(1);
               end
            end
         end
         default: begin
            rsp_valid_in = rsp_valid_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         vec_x_ff     <= '0;
         vec_y_ff     <= '0;
         step_ff      <= '0;
         iter_ff      <= '0;
         finished_ff  <= 1'b1;
         idle_ff      <= 1'b1;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         vec_x_ff     <= vec_x_in;
         vec_y_ff     <= vec_y_in;
         step_ff      <= step_in;
         iter_ff      <= iter_in;
         finished_ff  <= finished_in;
         idle_ff      <= idle_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      tmp_x_ff <= tmp_x_in;
      px_ff    <= px_in;
      py_ff    <= py_in;
      drawn_ff <= drawn_in;
      last_ff  <= last_in;
   end

endmodule

>>> rtl/core/rotation_arc_spoke_generator_core.sv
`timescale 1ns / 1ps
// arc / spoke point generator: one req word in, one rsp word out
// arc point: accept, then decide, emit, and one rotation in two halves (x, then y)
// through the single shared rotation unit before ready returns
// spoke point: decide, then turn_steps rotations, each an x half and a y half, then emit
// finished or empty figure: decide, then emit only; a held rsp word holds the sequencer
// in emit. reset clears configuration, figure stays finished until restart

module rotation_arc_spoke_generator_core import rasg_pkg::*; #(
   parameter int FRAC_BITS = 10,
   parameter int STEP_BITS = 10
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata,
   rasg_req_if.sink              req_chan,
   rasg_rsp_if.source            rsp_chan
);

   cfg_type cfg_ff, cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         unique case (csr_index)
            CSR_FIGURE_MODE:      cfg_in.figure_mode      = csr_wdata[0];
            CSR_CENTER_X:         cfg_in.center_x         = csr_wdata[PIX_W-1:0];
            CSR_CENTER_Y:         cfg_in.center_y         = csr_wdata[PIX_W-1:0];
            CSR_EXTENT:           cfg_in.extent           = csr_wdata[EXTENT_W-1:0];
            CSR_TURN_STEPS:       cfg_in.turn_steps       = csr_wdata[TURN_W-1:0];
            CSR_FIRST_DRAWN_STEP: cfg_in.first_drawn_step = csr_wdata[TURN_W-1:0];
            CSR_START_UP:         cfg_in.start_up         = csr_wdata[0];
            default:              cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   rasg_seq #(
      .FRAC_BITS (FRAC_BITS),
      .STEP_BITS (STEP_BITS)
   ) u_seq (
      .clock    (clock),
      .reset    (reset),
      .cfg      (cfg_ff),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

endmodule

>>> bench/rotation_arc_spoke_generator_core_tb.sv
`timescale 1ns / 1ps
// bench for rotation_arc_spoke_generator_core: directed and random restart/advance words,
// every point checked against an in-bench rotation predictor
// depends on rasg_pkg, rasg_req_if, rasg_rsp_if and the core itself

module rotation_arc_spoke_generator_core_tb;
   import rasg_pkg::*;

   localparam int FRAC_BITS     = 10;
   localparam int STEP_BITS     = 10;
   localparam int VEC_W         = FRAC_BITS + 10;
   localparam int SETTLE_CYCLES = 12;
   localparam int RANDOM_WORDS  = 1800;
   localparam int HOLD_CYCLES   = 300;
   localparam int CALM_FROM     = 1200;
   localparam int CALM_TO       = 1500;
   localparam bit [6:0] ALL_REGS = 7'h7f;

   typedef struct {
      logic signed [PIX_W-1:0] pixel_x;
      logic signed [PIX_W-1:0] pixel_y;
      logic                    drawn;
      logic                    last;
   } point_type;

   class figure_tracker;
      point_type               expected_points[$];
      int                      errors;
      cfg_type                 regs;
      logic signed [VEC_W-1:0] vec_x;
      logic signed [VEC_W-1:0] vec_y;
      logic [STEP_BITS-1:0]    step_index;
      bit                      finished;

      function new();
         regs       = '0;
         vec_x      = '0;
         vec_y      = '0;
         step_index = '0;
         finished   = 1'b1;
         errors     = 0;
      endfunction

      function void write_reg(logic [CSR_IDX_W-1:0] index, logic [CSR_DATA_W-1:0] data);
         case (index)
            CSR_FIGURE_MODE:      regs.figure_mode      = data[0];
            CSR_CENTER_X:         regs.center_x         = data;
            CSR_CENTER_Y:         regs.center_y         = data;
            CSR_EXTENT:           regs.extent           = data[EXTENT_W-1:0];
            CSR_TURN_STEPS:       regs.turn_steps       = data[TURN_W-1:0];
            CSR_FIRST_DRAWN_STEP: regs.first_drawn_step = data[TURN_W-1:0];
            CSR_START_UP:         regs.start_up         = data[0];
            default: ;
         endcase
      endfunction

      function logic signed [VEC_W-1:0] wrap_vec(longint value);
         return value[VEC_W-1:0];
      endfunction

      // one q10 rotation step, floor shift, wrapped to the vector width
      function void rotate_vec();
         longint nx;
         longint ny;
         nx = (longint'(ROT_COS) * longint'(vec_x) + longint'(ROT_SIN) * longint'(vec_y))
              >>> ROT_SHIFT;
         ny = (longint'(ROT_COS) * longint'(vec_y) - longint'(ROT_SIN) * longint'(vec_x))
              >>> ROT_SHIFT;
         vec_x = wrap_vec(nx);
         vec_y = wrap_vec(ny);
      endfunction

      function void predict_point(bit restart);
         point_type pt;
         int        count;
         longint    radius;
         longint    px;
         longint    py;
         count = regs.figure_mode ? int'(regs.extent) : int'(regs.turn_steps);
         if (restart) begin
            radius     = longint'(regs.extent) <<< FRAC_BITS;
            vec_x      = '0;
            vec_y      = wrap_vec(regs.start_up ? -radius : radius);
            step_index = '0;
            finished   = 1'b0;
         end
         // finished figure, or step count at or below the current step
         if (finished || int'(step_index) >= count) begin
            finished   = 1'b1;
            pt.pixel_x = '0;
            pt.pixel_y = '0;
            pt.drawn   = 1'b0;
            pt.last    = 1'b1;
            expected_points.push_back(pt);
            return;
         end
         if (regs.figure_mode) begin
            vec_x = '0;
            vec_y = wrap_vec(longint'(step_index) <<< FRAC_BITS);
            repeat (regs.turn_steps) rotate_vec();
            pt.drawn = 1'b1;
         end else begin
            pt.drawn = step_index >= regs.first_drawn_step;
         end
         pt.last = (int'(step_index) + 1 >= count) || (step_index == '1);
         px = longint'($signed(regs.center_x)) + (longint'(vec_x) >>> FRAC_BITS);
         py = longint'($signed(regs.center_y)) + (longint'(vec_y) >>> FRAC_BITS);
         pt.pixel_x = px[PIX_W-1:0];
         pt.pixel_y = py[PIX_W-1:0];
         expected_points.push_back(pt);
         if (!regs.figure_mode) begin
            rotate_vec();
         end
         if (pt.last) begin
            finished = 1'b1;
         end else begin
            step_index = step_index + 1'b1;
         end
      endfunction

      task report(string what);
         $display("%0t mismatch: %s", $time, what);
         errors++;
      endtask

      task check_point(point_type got);
         point_type want;
         if (expected_points.size() == 0) begin
            report($sformatf("point x=%0d y=%0d with nothing expected",
                             got.pixel_x, got.pixel_y));
            return;
         end
         want = expected_points.pop_front();
         if (got.pixel_x !== want.pixel_x) begin
            report($sformatf("pixel_x got %0d want %0d", got.pixel_x, want.pixel_x));
         end
         if (got.pixel_y !== want.pixel_y) begin
            report($sformatf("pixel_y got %0d want %0d", got.pixel_y, want.pixel_y));
         end
         if (got.drawn !== want.drawn) begin
            report($sformatf("drawn got %b want %b", got.drawn, want.drawn));
         end
         if (got.last !== want.last) begin
            report($sformatf("last got %b want %b", got.last, want.last));
         end
      endtask
   endclass

   logic                  clock = 1'b0;
   logic                  reset;
   logic                  csr_we;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_wdata;

   rasg_req_if req_bus ();
   rasg_rsp_if rsp_bus ();

   figure_tracker tracker;
   int            words_sent  = 0;
   int            points_seen = 0;
   int            heavy_left  = 12;
   int            hold_left   = 0;
   bit            hold_armed  = 1'b0;
   bit            hold_done   = 1'b0;

   rotation_arc_spoke_generator_core #(
      .FRAC_BITS(FRAC_BITS),
      .STEP_BITS(STEP_BITS)
   ) u_dut (
      .clock    (clock),
      .reset    (reset),
      .csr_we   (csr_we),
      .csr_index(csr_index),
      .csr_wdata(csr_wdata),
      .req_chan (req_bus),
      .rsp_chan (rsp_bus)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   initial begin
      #16_000_000;
      $display("TEST FAILED");
      $finish;
   end

   // result side: check every accepted word, stall at random or for the long hold
   always @(posedge clock) begin : rsp_side
      point_type got;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         got.pixel_x = rsp_bus.pixel_x;
         got.pixel_y = rsp_bus.pixel_y;
         got.drawn   = rsp_bus.drawn;
         got.last    = rsp_bus.last;
         tracker.check_point(got);
         points_seen++;
      end
      if (hold_armed && !hold_done) begin
         hold_done = 1'b1;
         hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_bus.ready <= 1'b0;
      end else begin
         rsp_bus.ready <= (points_seen >= CALM_FROM && points_seen < CALM_TO) ||
                          ($urandom_range(0, 99) >= 21);
      end
   end

   task automatic send_word(bit restart);
      while (!(words_sent >= CALM_FROM && words_sent < CALM_TO) &&
             $urandom_range(0, 99) < 21) begin
         req_bus.valid   <= 1'b0;
         req_bus.restart <= 1'($urandom);
         @(posedge clock);
      end
      req_bus.valid   <= 1'b1;
      req_bus.restart <= restart;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
      tracker.predict_point(restart);
      words_sent++;
   endtask

   // pattern bit 0 goes first
   task automatic send_bits(logic [31:0] pattern, int count);
      for (int k = 0; k < count; k++) begin
         send_word(pattern[k]);
      end
   endtask

   task automatic wait_idle();
      req_bus.valid <= 1'b0;
      @(posedge clock);
      while (tracker.expected_points.size() != 0) @(posedge clock);
      // the core may still be rotating after its last word left
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic program_regs(cfg_type c, bit [6:0] mask);
      logic [CSR_DATA_W-1:0] data;
      for (int i = CSR_FIGURE_MODE; i <= CSR_START_UP; i++) begin
         if (mask[i]) begin
            case (CSR_IDX_W'(i))
               CSR_FIGURE_MODE:      data = CSR_DATA_W'(c.figure_mode);
               CSR_CENTER_X:         data = c.center_x;
               CSR_CENTER_Y:         data = c.center_y;
               CSR_EXTENT:           data = CSR_DATA_W'(c.extent);
               CSR_TURN_STEPS:       data = CSR_DATA_W'(c.turn_steps);
               CSR_FIRST_DRAWN_STEP: data = CSR_DATA_W'(c.first_drawn_step);
               CSR_START_UP:         data = CSR_DATA_W'(c.start_up);
               default:              data = '0;
            endcase
            csr_we    <= 1'b1;
            csr_index <= CSR_IDX_W'(i);
            csr_wdata <= data;
            @(posedge clock);
            tracker.write_reg(CSR_IDX_W'(i), data);
         end
      end
      csr_we <= 1'b0;
      @(posedge clock);
   endtask

   function automatic cfg_type figure_regs(logic mode, logic [15:0] cx, logic [15:0] cy,
                                            logic [7:0] ext, logic [9:0] turn,
                                            logic [9:0] fds, logic up);
      cfg_type c;
      c.figure_mode      = mode;
      c.center_x         = cx;
      c.center_y         = cy;
      c.extent           = ext;
      c.turn_steps       = turn;
      c.first_drawn_step = fds;
      c.start_up         = up;
      return c;
   endfunction

   // light spokes keep rotations per point small, heavy ones take the full range
   function automatic cfg_type random_regs(bit heavy);
      cfg_type c;
      c.figure_mode = $urandom_range(0, 99) < 45;
      c.center_x    = ($urandom_range(0, 7) == 0) ? 16'h8000 : 16'($urandom);
      c.center_y    = ($urandom_range(0, 7) == 0) ? 16'h7fff : 16'($urandom);
      c.start_up    = 1'($urandom);
      if (c.figure_mode) begin
         c.extent     = ($urandom_range(0, 3) == 0) ? 8'($urandom) : 8'($urandom_range(0, 40));
         c.turn_steps = heavy ? 10'($urandom) : 10'($urandom_range(0, 12));
      end else begin
         c.extent     = 8'($urandom);
         c.turn_steps = heavy ? 10'($urandom) : 10'($urandom_range(0, 64));
      end
      c.first_drawn_step = $urandom_range(0, 1) ? 10'($urandom) :
                           10'($urandom_range(0, c.turn_steps));
      return c;
   endfunction

   task automatic directed_part();
      cfg_type c;
      // straight out of reset: figure finished, every count zero
      send_bits(32'b10, 2);
      wait_idle();
      // arc at the screen corners, largest radius, starting upward
      c = figure_regs(1'b0, 16'h7fff, 16'h8000, 8'd255, 10'd3, 10'd1, 1'b1);
      program_regs(c, ALL_REGS);
      send_bits(32'b0001, 4);
      wait_idle();
      // step count lowered under the running step
      c = figure_regs(1'b0, 16'hffff, 16'h0000, 8'd1, 10'd5, 10'd1023, 1'b0);
      program_regs(c, ALL_REGS);
      send_bits(32'b001, 3);
      wait_idle();
      c.turn_steps = 10'd2;
      program_regs(c, 7'd1 << CSR_TURN_STEPS);
      send_bits(32'b0, 1);
      wait_idle();
      // arc switched to spoke mid-figure keeps its step index
      c = figure_regs(1'b0, 16'd100, 16'hff38, 8'd100, 10'd20, 10'd0, 1'b0);
      program_regs(c, ALL_REGS);
      send_bits(32'b001, 3);
      wait_idle();
      c.figure_mode = 1'b1;
      c.turn_steps  = 10'd7;
      program_regs(c, (7'd1 << CSR_FIGURE_MODE) | (7'd1 << CSR_TURN_STEPS));
      send_bits(32'b00, 2);
      wait_idle();
      // spoke with the most rotations per point
      c = figure_regs(1'b1, 16'h8000, 16'h7fff, 8'd3, 10'd1023, 10'd0, 1'b1);
      program_regs(c, ALL_REGS);
      send_bits(32'b0001, 4);
      wait_idle();
      // spoke of zero length, then full length with no rotation
      c = figure_regs(1'b1, 16'd5, 16'd5, 8'd0, 10'd4, 10'd0, 1'b0);
      program_regs(c, ALL_REGS);
      send_bits(32'b1, 1);
      wait_idle();
      c.extent     = 8'd255;
      c.turn_steps = 10'd0;
      program_regs(c, (7'd1 << CSR_EXTENT) | (7'd1 << CSR_TURN_STEPS));
      send_bits(32'b01, 2);
      wait_idle();
      // restart in the middle of an arc
      c = figure_regs(1'b0, 16'd0, 16'd0, 8'd10, 10'd10, 10'd3, 1'b1);
      program_regs(c, ALL_REGS);
      send_bits(32'b101, 3);
      wait_idle();
   endtask

   // a long arc while the result side holds off
   task automatic long_hold_phase();
      cfg_type c;
      c = figure_regs(1'b0, 16'($urandom), 16'($urandom), 8'd200, 10'd300, 10'd0,
                      1'($urandom));
      program_regs(c, ALL_REGS);
      hold_armed = 1'b1;
      send_word(1'b1);
      repeat (299) send_word(1'b0);
      wait_idle();
   endtask

   task automatic random_phase();
      cfg_type c;
      int      kind;
      int      span;
      int      n;
      int      index;
      bit      heavy;
      kind = $urandom_range(0, 99);
      if (kind < 15) begin
         // carry on with the running figure under changed registers
         c            = random_regs(1'b0);
         c.turn_steps = 10'($urandom_range(0, 31));
         index        = $urandom_range(CSR_FIGURE_MODE, CSR_START_UP);
         program_regs(c, (7'd1 << CSR_TURN_STEPS) | (7'd1 << index));
         n = $urandom_range(1, 20);
         repeat (n) send_word($urandom_range(0, 99) < 5);
      end else if (kind < 25) begin
         c = random_regs(1'b0);
         program_regs(c, ALL_REGS);
         n = $urandom_range(1, 15);
         repeat (n) send_word(1'($urandom));
      end else begin
         heavy = ($urandom_range(0, 9) == 0) && (heavy_left > 0);
         c     = random_regs(heavy);
         if (heavy && c.figure_mode) begin
            heavy_left--;
         end
         program_regs(c, ALL_REGS);
         span = c.figure_mode ? int'(c.extent) : int'(c.turn_steps);
         n    = span + int'($urandom_range(0, 3)) - 1;
         if (heavy && c.figure_mode && n > 2) begin
            n = 2;
         end
         if (n > 120) begin
            n = 120;
         end
         send_word(1'b1);
         for (int k = 0; k < n; k++) begin
            send_word($urandom_range(0, 99) < 3);
         end
      end
      wait_idle();
   endtask

   initial begin
      int target;
      tracker         = new();
      reset           = 1'b1;
      csr_we          = 1'b0;
      csr_index       = '0;
      csr_wdata       = '0;
      req_bus.valid   = 1'b0;
      req_bus.restart = 1'b0;
      rsp_bus.ready   = 1'b0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      directed_part();
      target = words_sent + RANDOM_WORDS;
      while (words_sent < target) begin
         if (!hold_armed && words_sent >= 600) begin
            long_hold_phase();
         end else begin
            random_phase();
         end
      end

      repeat (50) @(posedge clock);
      if (tracker.expected_points.size() != 0) begin
         tracker.report($sformatf("%0d points never produced",
                                  tracker.expected_points.size()));
      end
      if (tracker.errors == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule
